@@ hw/rtl/cartesian_to_polar_defines.svh @@
// Assertion macros shared by the cartesian_to_polar checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CARTESIAN_TO_POLAR_DEFINES_SVH
`define CARTESIAN_TO_POLAR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ctp_pkg.sv @@
// Package for the Cartesian-to-polar converter: constants, arctangent table
// and the control struct passed between pipeline stages. No dependencies.
package ctp_pkg;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_COORD_WIDTH   = 16;

  localparam int GUARD_BITS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int ANG_FRAC   = 24;
  localparam int ZW         = 29;
  localparam int MAG_W      = 16;
  localparam int ANG_W      = 16;
  localparam int GAIN_W     = 30;

  localparam logic [GAIN_W-1:0]    INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] PI_Q24       = 29'sd52707179;
  localparam logic signed [ANG_W-1:0] ANG_MAX   = 16'sd25736;

  typedef struct packed {
    logic valid;
    logic origin;
  } ctp_ctl_t;

  // atan(2^-idx) in radians, Q.24, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:       val = 29'sd13176795;
      1:       val = 29'sd7778716;
      2:       val = 29'sd4110060;
      3:       val = 29'sd2086331;
      4:       val = 29'sd1047214;
      5:       val = 29'sd524117;
      6:       val = 29'sd262123;
      7:       val = 29'sd131069;
      8:       val = 29'sd65536;
      9:       val = 29'sd32768;
      10:      val = 29'sd16384;
      11:      val = 29'sd8192;
      12:      val = 29'sd4096;
      13:      val = 29'sd2048;
      14:      val = 29'sd1024;
      15:      val = 29'sd512;
      16:      val = 29'sd256;
      17:      val = 29'sd128;
      18:      val = 29'sd64;
      19:      val = 29'sd32;
      20:      val = 29'sd16;
      21:      val = 29'sd8;
      22:      val = 29'sd4;
      23:      val = 29'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/ctp_stage.sv @@
// One registered CORDIC vectoring micro-rotation.
// Depends on ctp_pkg for the arctangent table and the control struct.
module ctp_stage #(
  parameter int DW  = 35,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  ctp_pkg::ctp_ctl_t           ctl_i,
  input  logic signed [DW-1:0]        x_i,
  input  logic signed [DW-1:0]        y_i,
  input  logic signed [ctp_pkg::ZW-1:0] z_i,
  output ctp_pkg::ctp_ctl_t           ctl_o,
  output logic signed [DW-1:0]        x_o,
  output logic signed [DW-1:0]        y_o,
  output logic signed [ctp_pkg::ZW-1:0] z_o
);

  ctp_pkg::ctp_ctl_t             ctl_r;
  logic signed [DW-1:0]          x_r, y_r, x_nxt, y_nxt;
  logic signed [ctp_pkg::ZW-1:0] z_r, z_nxt;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    if (!y_i[DW-1]) begin
      x_nxt = x_i + (y_i >>> IDX);
      y_nxt = y_i - (x_i >>> IDX);
      z_nxt = z_i + ctp_pkg::atan_q24(IDX);
    end else begin
      x_nxt = x_i - (y_i >>> IDX);
      y_nxt = y_i + (x_i >>> IDX);
      z_nxt = z_i - ctp_pkg::atan_q24(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

@@ hw/rtl/ctp_post.sv @@
// Gain correction and rounding after the CORDIC: two register stages
// (partial products, then sums) and the final rounding and clamping logic.
// Depends on ctp_pkg.
module ctp_post #(
  parameter int DW = 35
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  ctp_pkg::ctp_ctl_t             ctl_i,
  input  logic signed [DW-1:0]          x_i,
  input  logic signed [ctp_pkg::ZW-1:0] z_i,
  output ctp_pkg::ctp_ctl_t             ctl_o,
  output logic [ctp_pkg::MAG_W-1:0]     mag_o,
  output logic signed [ctp_pkg::ANG_W-1:0] ang_o
);

  localparam int MW        = (DW > 48) ? DW : 48;
  localparam int TOPW      = MW - 32;
  localparam int PW        = TOPW + ctp_pkg::GAIN_W;
  localparam int LW        = 16 + ctp_pkg::GAIN_W;
  localparam int TW        = MW + 15;
  localparam int RW        = ctp_pkg::ZW - 10;
  localparam int ANG_SHIFT = ctp_pkg::ANG_FRAC - 13;
  localparam logic [ctp_pkg::ZW:0] ANG_HALF = (ctp_pkg::ZW + 1)'(1) << (ANG_SHIFT - 1);
  localparam logic [TW-1:0] MAG_HALF = TW'(1) << (ctp_pkg::GAIN_W - 1);
  localparam logic [RW-1:0] ANG_LIM  = RW'(ctp_pkg::ANG_MAX);

  ctp_pkg::ctp_ctl_t ctl_a_r, ctl_b_r;

  // Multiply stage.
  logic [MW-1:0]             xu;
  logic [PW-1:0]             p_top_nxt, p_top_r;
  logic [LW-1:0]             p_mid_nxt, p_mid_r, p_lo_nxt, p_lo_r;
  logic [ctp_pkg::ZW-1:0]    zabs_nxt, zabs_r;
  logic                      zneg_a_r, zneg_b_r;

  // Sum stage.
  logic [TW-1:0]             t_nxt, t_r;
  logic [ctp_pkg::ZW:0]      rsum;
  logic [RW-1:0]             rang_nxt, rang_r;

  // Output logic.
  logic [TW-1:0]             msum;
  logic [TW-ctp_pkg::GAIN_W-1:0] mq;
  logic [ctp_pkg::MAG_W-1:0] mag_sat;
  logic signed [ctp_pkg::ANG_W-1:0] rclamp;

  // The final x is never negative, so it is split into three 16-bit-ish
  // slices to keep each product narrow.
  assign xu        = MW'($unsigned(x_i));
  assign p_top_nxt = PW'(xu[MW-1:32]) * PW'(ctp_pkg::INV_GAIN_Q30);
  assign p_mid_nxt = LW'(xu[31:16]) * LW'(ctp_pkg::INV_GAIN_Q30);
  assign p_lo_nxt  = LW'(xu[15:0]) * LW'(ctp_pkg::INV_GAIN_Q30);
  assign zabs_nxt  = z_i[ctp_pkg::ZW-1] ? $unsigned(-z_i) : $unsigned(z_i);

  assign t_nxt    = (TW'(p_top_r) << 16) + TW'(p_mid_r) + TW'(p_lo_r >> 16);
  assign rsum     = (ctp_pkg::ZW + 1)'(zabs_r) + ANG_HALF;
  assign rang_nxt = rsum[ctp_pkg::ZW:ANG_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_top_r  <= p_top_nxt;
      p_mid_r  <= p_mid_nxt;
      p_lo_r   <= p_lo_nxt;
      zabs_r   <= zabs_nxt;
      zneg_a_r <= z_i[ctp_pkg::ZW-1];
      t_r      <= t_nxt;
      rang_r   <= rang_nxt;
      zneg_b_r <= zneg_a_r;
    end
  end

  // Round half up, then saturate to the output width.
  assign msum    = t_r + MAG_HALF;
  assign mq      = msum[TW-1:ctp_pkg::GAIN_W];
  assign mag_sat = (|mq[TW-ctp_pkg::GAIN_W-1:ctp_pkg::MAG_W]) ? '1 : mq[ctp_pkg::MAG_W-1:0];

  // The angle was rounded as a magnitude, so the sign goes back on last.
  assign rclamp = (rang_r > ANG_LIM) ? ctp_pkg::ANG_MAX : $signed(rang_r[ctp_pkg::ANG_W-1:0]);

  assign ctl_o = ctl_b_r;
  assign mag_o = ctl_b_r.origin ? '0 : mag_sat;
  assign ang_o = ctl_b_r.origin ? '0 : (zneg_b_r ? -rclamp : rclamp);

endmodule

@@ hw/rtl/cartesian_to_polar.sv @@
// Cartesian-to-polar converter: pipelined CORDIC in vectoring mode.
// Pipeline from input accept to out_valid: one fold stage,
// one stage per micro-rotation, two gain stages, the output register.
// Throughput is one item per cycle; a stalled output fills a one-entry skid
// buffer, and in_stall is raised from that buffer while it is full.
// Synchronous active-low reset clears only the valid and origin control bits.
module cartesian_to_polar #(
  parameter int CORDIC_STAGES = ctp_pkg::DEF_CORDIC_STAGES,
  parameter int COORD_WIDTH   = ctp_pkg::DEF_COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_WIDTH-1:0]    in_x_coord,
  input  logic signed [COORD_WIDTH-1:0]    in_y_coord,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ctp_pkg::MAG_W-1:0]        out_magnitude,
  output logic signed [ctp_pkg::ANG_W-1:0] out_angle
);

  localparam int NS = (CORDIC_STAGES > ctp_pkg::TABLE_LEN) ? ctp_pkg::TABLE_LEN : CORDIC_STAGES;
  localparam int DW = COORD_WIDTH + ctp_pkg::GUARD_BITS + 3;

  logic                          en;
  logic signed [DW-1:0]          xe, ye, xf_nxt, yf_nxt;
  logic signed [ctp_pkg::ZW-1:0] zf_nxt;
  ctp_pkg::ctp_ctl_t             ctlf_nxt;

  ctp_pkg::ctp_ctl_t             cs [NS+1];
  logic signed [DW-1:0]          xs [NS+1];
  logic signed [DW-1:0]          ys [NS+1];
  logic signed [ctp_pkg::ZW-1:0] zs [NS+1];

  ctp_pkg::ctp_ctl_t                post_ctl;
  logic [ctp_pkg::MAG_W-1:0]        post_mag;
  logic signed [ctp_pkg::ANG_W-1:0] post_ang;

  logic                             out_valid_r, skid_v_r, out_free;
  logic [ctp_pkg::MAG_W-1:0]        out_mag_r, skid_mag_r;
  logic signed [ctp_pkg::ANG_W-1:0] out_ang_r, skid_ang_r;

  // The pipeline up to the output register advances unless the skid buffer holds an item.
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Fold the left half-plane onto the right one and start the angle at +/-pi.
  assign xe = DW'(in_x_coord);
  assign ye = DW'(in_y_coord);

  always_comb begin
    ctlf_nxt.valid  = in_valid;
    ctlf_nxt.origin = (in_x_coord == '0) && (in_y_coord == '0);
    if (in_x_coord[COORD_WIDTH-1]) begin
      xf_nxt = (-xe) <<< ctp_pkg::GUARD_BITS;
      yf_nxt = (-ye) <<< ctp_pkg::GUARD_BITS;
      zf_nxt = in_y_coord[COORD_WIDTH-1] ? -ctp_pkg::PI_Q24 : ctp_pkg::PI_Q24;
    end else begin
      xf_nxt = xe <<< ctp_pkg::GUARD_BITS;
      yf_nxt = ye <<< ctp_pkg::GUARD_BITS;
      zf_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs[0] <= '0;
    end else if (en) begin
      cs[0] <= ctlf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= xf_nxt;
      ys[0] <= yf_nxt;
      zs[0] <= zf_nxt;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    ctp_stage #(
      .DW  (DW),
      .IDX (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (cs[i]),
      .x_i   (xs[i]),
      .y_i   (ys[i]),
      .z_i   (zs[i]),
      .ctl_o (cs[i+1]),
      .x_o   (xs[i+1]),
      .y_o   (ys[i+1]),
      .z_o   (zs[i+1])
    );
  end

  ctp_post #(
    .DW (DW)
  ) u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (cs[NS]),
    .x_i   (xs[NS]),
    .z_i   (zs[NS]),
    .ctl_o (post_ctl),
    .mag_o (post_mag),
    .ang_o (post_ang)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= post_ctl.valid;
      end
    end else if (post_ctl.valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_mag_r <= skid_v_r ? skid_mag_r : post_mag;
      out_ang_r <= skid_v_r ? skid_ang_r : post_ang;
    end else if (en) begin
      skid_mag_r <= post_mag;
      skid_ang_r <= post_ang;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_mag_r;
  assign out_angle     = out_ang_r;

endmodule

@@ hw/rtl/ctp_checker.sv @@
// Port-level checks for cartesian_to_polar, attached by the bind below.
// Depends on ctp_pkg and cartesian_to_polar_defines.svh.
`include "cartesian_to_polar_defines.svh"

module ctp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [ctp_pkg::MAG_W-1:0]        out_magnitude,
  input logic signed [ctp_pkg::ANG_W-1:0] out_angle
);

  // A result waiting on a stalled output must not change.
  `CTP_ASSERT_NXT(a_out_hold, out_valid && out_stall, $stable(out_magnitude) && $stable(out_angle), "stalled result changed")

  // The angle never leaves the range of -pi to +pi.
  `CTP_ASSERT_IMP(a_ang_range, out_valid, ($signed(out_angle) <= ctp_pkg::ANG_MAX) && ($signed(out_angle) >= -ctp_pkg::ANG_MAX), "angle out of range")

  // Only the origin gives a zero radius, and its angle is zero.
  `CTP_ASSERT_IMP(a_origin, out_valid && (out_magnitude == '0), out_angle == '0, "zero radius with nonzero angle")

  // Input backpressure appears only after a stalled result.
  `CTP_ASSERT_IMP(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "input stalled without output stall")

  // Once the waiting result is taken, the buffered item moves up and input opens again.
  `CTP_ASSERT_NXT(a_stall_clear, in_stall && out_valid && !out_stall, !in_stall && out_valid, "skid buffer did not drain")

endmodule

bind cartesian_to_polar ctp_checker u_ctp_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Testbench for cartesian_to_polar: directed and random points against a built-in
// bit-exact CORDIC predictor. Depends on ctp_pkg and the cartesian_to_polar RTL.
module tb;

  localparam int    NUM_STAGES   = 16;
  localparam int    FRAC_GUARD   = 16;
  localparam longint PI_ACC      = 64'sd52707179;
  localparam longint PI_OUT      = 64'sd25736;
  localparam longint GAIN_INV    = 64'sd652032874;
  localparam int    RANDOM_ITEMS = 1600;
  localparam int    CYCLE_LIMIT  = 300000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic signed [15:0]               xc;
    logic signed [15:0]               yc;
    logic [ctp_pkg::MAG_W-1:0]        mag;
    logic signed [ctp_pkg::ANG_W-1:0] ang;
  } polar_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic signed [15:0]               in_x_coord = '0;
  logic signed [15:0]               in_y_coord = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [ctp_pkg::MAG_W-1:0]        out_magnitude;
  logic signed [ctp_pkg::ANG_W-1:0] out_angle;

  polar_t      pending_polar[$];
  int          cycle_count = 0;
  int          error_count = 0;
  int          points_sent = 0;
  int          points_checked = 0;
  int          directed_points = 0;
  int          in_stall_cycles = 0;
  int          out_stall_cycles = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode;

  cartesian_to_polar u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_coord   (in_x_coord),
    .in_y_coord   (in_y_coord),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_magnitude(out_magnitude),
    .out_angle    (out_angle)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_polar.size());
      $display("** cartesian_to_polar: FAILED **");
      $finish;
    end
  end

  // arctangent of 2^-i in radians, scaled by 2^24
  function automatic longint micro_angle(input int i);
    longint val;
    case (i)
      0:  val = 13176795;
      1:  val = 7778716;
      2:  val = 4110060;
      3:  val = 2086331;
      4:  val = 1047214;
      5:  val = 524117;
      6:  val = 262123;
      7:  val = 131069;
      8:  val = 65536;
      9:  val = 32768;
      10: val = 16384;
      11: val = 8192;
      12: val = 4096;
      13: val = 2048;
      14: val = 1024;
      15: val = 512;
      16: val = 256;
      17: val = 128;
      18: val = 64;
      19: val = 32;
      20: val = 16;
      21: val = 8;
      22: val = 4;
      default: val = 2;
    endcase
    return val;
  endfunction

  function automatic polar_t predict_polar(input logic signed [15:0] xc,
                                           input logic signed [15:0] yc);
    longint          px;
    longint          py;
    longint          pz;
    longint          sx;
    longint          sy;
    longint          rounded;
    longint unsigned ux;
    longint unsigned scaled;
    polar_t          res;
    res.xc = xc;
    res.yc = yc;
    px = xc;
    py = yc;
    pz = 0;
    if (px == 0 && py == 0) begin
      res.mag = '0;
      res.ang = '0;
      return res;
    end
    // Fold the left half-plane onto the right, starting the angle at +pi or -pi.
    if (px < 0) begin
      pz = (py >= 0) ? PI_ACC : -PI_ACC;
      px = -px;
      py = -py;
    end
    px = px * (64'sd1 <<< FRAC_GUARD);
    py = py * (64'sd1 <<< FRAC_GUARD);
    for (int i = 0; i < NUM_STAGES && i < 24; i++) begin
      sx = px >>> i;
      sy = py >>> i;
      if (py >= 0) begin
        px = px + sy;
        py = py - sx;
        pz = pz + micro_angle(i);
      end else begin
        px = px - sy;
        py = py + sx;
        pz = pz - micro_angle(i);
      end
    end
    // Gain correction split into high and low halves to keep the product in range.
    ux = px;
    scaled = (ux >> 16) * GAIN_INV + (((ux & 64'hFFFF) * GAIN_INV) >> 16);
    scaled = (scaled + (64'd1 << 29)) >> 30;
    res.mag = (scaled > 64'hFFFF) ? 16'hFFFF : scaled[15:0];
    if (pz < 0) rounded = -((-pz + 1024) >>> 11);
    else rounded = (pz + 1024) >>> 11;
    if (rounded > PI_OUT) rounded = PI_OUT;
    if (rounded < -PI_OUT) rounded = -PI_OUT;
    res.ang = rounded[15:0];
    return res;
  endfunction

  // Sends one point, opening a new burst after a random gap when the last one ran out.
  task automatic send_point(input logic signed [15:0] xc, input logic signed [15:0] yc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_x_coord <= xc;
    in_y_coord <= yc;
    @(posedge clk);
    while (in_stall) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    pending_polar.push_back(predict_polar(xc, yc));
    points_sent++;
  endtask

  function automatic logic signed [15:0] corner_coord();
    logic signed [15:0] val;
    case ($urandom_range(0, 6))
      0: val = -16'sd32768;
      1: val = -16'sd32767;
      2: val = -16'sd1;
      3: val = 16'sd0;
      4: val = 16'sd1;
      5: val = 16'sd32766;
      default: val = 16'sd32767;
    endcase
    return val;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= ((cycle_count % 7) < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  assign stall_mode = stall_mode_t'(cycle_count[9:8]);

  always @(posedge clk) begin
    polar_t want;
    if (rst_n && out_stall) out_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_polar.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected item, magnitude %0d angle %0d", $time,
                 out_magnitude, out_angle);
      end else begin
        want = pending_polar.pop_front();
        points_checked++;
        if (out_magnitude !== want.mag) begin
          error_count++;
          $display("%0t ns: magnitude of (%0d,%0d) expected %0d, got %0d", $time,
                   want.xc, want.yc, want.mag, out_magnitude);
        end
        if (out_angle !== want.ang) begin
          error_count++;
          $display("%0t ns: angle of (%0d,%0d) expected %0d, got %0d", $time,
                   want.xc, want.yc, want.ang, out_angle);
        end
      end
    end
  end

  task automatic test_origin();
    send_point(16'sd0, 16'sd0);
  endtask

  // Points on the axes; negative x with zero y must come out as +pi.
  task automatic test_axes();
    send_point(16'sd32767, 16'sd0);
    send_point(-16'sd32768, 16'sd0);
    send_point(16'sd0, 16'sd32767);
    send_point(16'sd0, -16'sd32768);
    send_point(16'sd1, 16'sd0);
    send_point(-16'sd1, 16'sd0);
    send_point(16'sd0, 16'sd1);
    send_point(16'sd0, -16'sd1);
  endtask

  task automatic test_extremes();
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
    send_point(-16'sd32768, 16'sd32767);
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(-16'sd32768, -16'sd1);
    send_point(-16'sd32768, 16'sd1);
    send_point(-16'sd1, 16'sd32767);
    send_point(16'sd3, -16'sd4);
  endtask

  task automatic test_random_points();
    logic signed [15:0] xc;
    logic signed [15:0] yc;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        6: begin
          xc = $signed(16'($urandom_range(0, 32))) - 16'sd16;
          yc = $signed(16'($urandom_range(0, 32))) - 16'sd16;
        end
        7: begin
          xc = $signed(16'($urandom));
          yc = $signed(16'($urandom_range(0, 4))) - 16'sd2;
          if ($urandom_range(0, 1)) {xc, yc} = {yc, xc};
        end
        8: begin
          xc = corner_coord();
          yc = corner_coord();
        end
        9: begin
          xc = $signed(16'($urandom)) >>> $urandom_range(0, 15);
          yc = $signed(16'($urandom)) >>> $urandom_range(0, 15);
        end
        default: begin
          xc = $signed(16'($urandom));
          yc = $signed(16'($urandom));
        end
      endcase
      send_point(xc, yc);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_origin();
    test_axes();
    test_extremes();
    directed_points = points_sent;
    test_random_points();
    in_valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Checked %0d of %0d points (%0d directed) in %0d cycles.",
             points_checked, points_sent, directed_points, cycle_count);
    $display("Input held off for %0d cycles, output stalled for %0d cycles.",
             in_stall_cycles, out_stall_cycles);
    if (error_count == 0) begin
      $display("** cartesian_to_polar: PASSED **");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("** cartesian_to_polar: FAILED **");
    end
    $finish;
  end

endmodule
